### rtl/core/ccwc_pkg.sv
// Shared constants, types and state encoding for the coin change way counter.
// Used by ccwc_ctrl, ccwc_dp and coin_change_way_count; depends on nothing.
`default_nettype none

package ccwc_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int WAY_W       = 30;
    localparam int COIN_W      = 16;
    localparam int TARGET_W    = 10;
    localparam int CALC_W      = ((ADDR_W > COIN_W) ? ADDR_W : COIN_W) + 1;
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [WAY_W-1:0] WAY_MODULUS = WAY_W'(1000000007);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } ccwc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch coin and target, restart the walk at amount 0
        logic step;      // issue the table reads for the current amount
        logic seed;      // first coin of a set: rewrite instead of accumulate
        logic push_out;  // move the finished count into the output register
    } ccwc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_end;  // the current amount is the target
    } ccwc_status_t;

endpackage

`default_nettype wire

### rtl/core/ccwc_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module ccwc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### rtl/core/ccwc_dp.sv
// Datapath of the coin change way counter: amount counter, table RAM,
// modular accumulate stage with write forwarding, result and output registers.
// Depends on ccwc_pkg and ccwc_ram.
`default_nettype none

module ccwc_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ccwc_pkg::ccwc_cmd_t              cmd,
    input  wire logic [ccwc_pkg::COIN_W-1:0]      coin_in,
    input  wire logic [ccwc_pkg::TARGET_W-1:0]    target_in,
    output ccwc_pkg::ccwc_status_t                status,
    output logic      [ccwc_pkg::WAY_W-1:0]       way_count
);

    localparam int AW = ccwc_pkg::ADDR_W;
    localparam int WW = ccwc_pkg::WAY_W;
    localparam int CW = ccwc_pkg::COIN_W;
    localparam int XW = ccwc_pkg::CALC_W;

    // Issue stage
    logic [CW-1:0] coin_reg;
    logic [AW-1:0] top_reg;
    logic [AW-1:0] top_next;
    logic [AW-1:0] amt_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic [CW:0]   rem_inc;
    logic [XW-1:0] diff;
    logic          ge_coin;
    logic [AW-1:0] low_addr;

    // Accumulate stage
    logic          v1_reg;
    logic [AW-1:0] amt1_reg;
    logic [AW-1:0] low1_reg;
    logic          ge1_reg;
    logic          mult1_reg;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [WW-1:0] fwd_data_reg;
    logic [WW-1:0] rdata_a;
    logic [WW-1:0] rdata_b;
    logic [WW-1:0] low_val;
    logic [WW:0]   sum;
    logic [WW-1:0] sum_mod;
    logic [WW-1:0] new_val;
    logic [WW-1:0] result_reg;
    logic [WW-1:0] way_reg;

    always_comb
    begin
        if (32'(target_in) >= ccwc_pkg::TABLE_DEPTH)
        begin
            top_next = AW'(ccwc_pkg::TABLE_DEPTH - 1);
        end
        else
        begin
            top_next = AW'(target_in);
        end
        diff     = XW'(amt_reg) - XW'(coin_reg);
        ge_coin  = !diff[XW-1] && (coin_reg != '0);
        low_addr = diff[AW-1:0];
        // Remainder of the amount by the coin, kept by counting so no divider is needed.
        rem_inc  = {1'b0, rem_reg} + (CW+1)'(1);
        rem_next = (rem_inc == {1'b0, coin_reg}) ? '0 : rem_inc[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            coin_reg <= coin_in;
            top_reg  <= top_next;
            amt_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.step)
        begin
            amt_reg <= amt_reg + AW'(1);
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= cmd.step;
            fwd_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        amt1_reg     <= amt_reg;
        low1_reg     <= low_addr;
        ge1_reg      <= ge_coin;
        mult1_reg    <= (rem_reg == '0);
        fwd_addr_reg <= amt1_reg;
        fwd_data_reg <= new_val;
        if (v1_reg && (amt1_reg == top_reg))
        begin
            result_reg <= new_val;
        end
        if (cmd.push_out)
        begin
            way_reg <= result_reg;
        end
    end

    ccwc_ram #(
        .WIDTH (WW),
        .DEPTH (ccwc_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (v1_reg),
        .waddr   (amt1_reg),
        .wdata   (new_val),
        .raddr_a (amt_reg),
        .raddr_b (low_addr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        // The entry one coin lower may have been written in the previous cycle,
        // while the RAM still returned its old contents.
        if (fwd_valid_reg && (fwd_addr_reg == low1_reg))
        begin
            low_val = fwd_data_reg;
        end
        else
        begin
            low_val = rdata_b;
        end
        sum = {1'b0, rdata_a} + {1'b0, low_val};
        if (sum >= {1'b0, ccwc_pkg::WAY_MODULUS})
        begin
            sum_mod = WW'(sum - {1'b0, ccwc_pkg::WAY_MODULUS});
        end
        else
        begin
            sum_mod = sum[WW-1:0];
        end
        if (cmd.seed)
        begin
            new_val = mult1_reg ? WW'(1) : '0;
        end
        else if (amt1_reg == '0)
        begin
            new_val = WW'(1);
        end
        else if (ge1_reg)
        begin
            new_val = sum_mod;
        end
        else
        begin
            new_val = rdata_a;
        end
    end

    assign status.walk_end = (amt_reg == top_reg);
    assign way_count       = way_reg;

endmodule

`default_nettype wire

### rtl/core/ccwc_ctrl.sv
// Controller of the coin change way counter: input and output handshakes,
// set tracking and sequencing of the table walk. Depends on ccwc_pkg.
`default_nettype none

module ccwc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   last_coin,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire ccwc_pkg::ccwc_status_t status,
    output ccwc_pkg::ccwc_cmd_t         cmd
);

    ccwc_pkg::ccwc_state_t state_reg;
    ccwc_pkg::ccwc_state_t state_next;
    logic first_reg;
    logic first_next;
    logic last_reg;
    logic last_next;
    logic seed_reg;
    logic seed_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ccwc_pkg::ST_IDLE;
            first_reg     <= 1'b1;
            last_reg      <= 1'b0;
            seed_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        seed_next    = seed_reg;
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.seed     = seed_reg;
        cmd.push_out = 1'b0;

        case (state_reg)
            ccwc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    seed_next  = first_reg;
                    last_next  = last_coin;
                    first_next = last_coin;
                    state_next = ccwc_pkg::ST_WALK;
                end
            end
            ccwc_pkg::ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.walk_end)
                begin
                    state_next = ccwc_pkg::ST_DRAIN;
                end
            end
            ccwc_pkg::ST_DRAIN:
            begin
                state_next = last_reg ? ccwc_pkg::ST_FINISH : ccwc_pkg::ST_IDLE;
            end
            ccwc_pkg::ST_FINISH:
            begin
                // Wait here only while the previous count is still unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.push_out = 1'b1;
                    state_next   = ccwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ccwc_pkg::ST_IDLE;
            end
        endcase

        if (cmd.push_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/core/coin_change_way_count.sv
// Top level of the coin change way counter: configuration register, controller
// and datapath. Depends on ccwc_pkg, ccwc_ctrl, ccwc_dp and ccwc_ram.
//
// Usage: write target_amount through the APB port at address 0 while idle.
// Coins then arrive one item at a time on the input channel (coin_value,
// last_coin, in_valid/in_ready). A set of coins ends with the item whose
// last_coin is high; that item alone produces one result item, way_count, the
// number of combinations for the target modulo 1000000007.
// Each coin walks the table from amount 0 to the target, one amount per cycle
// through a read-accumulate-write loop on the table RAM, so one item occupies
// the block for its whole walk, and a last coin also while its result moves out.
// in_ready is high only between items. The result sits in an output register:
// the next set may start while it waits; if a further result completes before
// out_ready takes the first, the block holds until the output register frees.
// Reset clears target_amount to 0, empties the output and starts a new set;
// the table needs no clearing, since the first coin of a set rewrites it.
`default_nettype none

module coin_change_way_count (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ccwc_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ccwc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [ccwc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [ccwc_pkg::COIN_W-1:0]        coin_value,
    input  wire logic                               last_coin,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [ccwc_pkg::WAY_W-1:0]         way_count
);

    logic [ccwc_pkg::TARGET_W-1:0] target_reg;
    ccwc_pkg::ccwc_cmd_t           cmd;
    ccwc_pkg::ccwc_status_t        status;
    logic                          cfg_write;

    // There is a single register, so every address within the port decodes to it.
    assign cfg_write = psel && penable && pwrite && (paddr[1:0] == 2'b00 || paddr != '0);
    assign pready    = 1'b1;
    assign prdata    = ccwc_pkg::APB_DATA_W'(target_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_write)
        begin
            target_reg <= pwdata[ccwc_pkg::TARGET_W-1:0];
        end
    end

    ccwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_coin (last_coin),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ccwc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .coin_in   (coin_value),
        .target_in (target_reg),
        .status    (status),
        .way_count (way_count)
    );

endmodule

`default_nettype wire
